/* design/assert_macros.svh */
// assertion macros used by the checker file segit_checker.sv
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SEGIT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// expression must never be true outside reset
`define SEGIT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

/* design/segit_pkg.sv */
// widths, types and helpers for the segment intersection test pipeline
// no dependencies
package segit_pkg;

  // coordinate width of the input ports
  localparam int COORD_BITS = 31;
  // a coordinate difference needs one more bit
  localparam int DIFF_W = COORD_BITS + 1;
  // product of two differences
  localparam int PROD_W = 2 * DIFF_W;
  // sum or difference of two products
  localparam int SUM_W = PROD_W + 1;
  // cycles from accepted transaction to result strobe
  localparam int LATENCY = 4;

  // slots of the four point/segment tests
  localparam int TestCount = 4;
  localparam int T_ABC = 0;  // point c against segment ab
  localparam int T_ABD = 1;  // point d against segment ab
  localparam int T_CDA = 2;  // point a against segment cd
  localparam int T_CDB = 3;  // point b against segment cd

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // differences on one axis
  typedef struct packed {
    diff_t ba;
    diff_t ca;
    diff_t da;
    diff_t dc;
    diff_t ac;
    diff_t bc;
    diff_t ad;
    diff_t bd;
    diff_t cb;
    diff_t db;
  } diffs_t;

  // two partial products of one cross or dot product
  typedef struct packed {
    prod_t p0;
    prod_t p1;
  } pair_t;

  // sign-extended difference p - q
  function automatic diff_t sub(coord_t p, coord_t q);
    return diff_t'(p) - diff_t'(q);
  endfunction

  // full-width signed product
  function automatic prod_t mul(diff_t p, diff_t q);
    prod_t pe;
    prod_t qe;
    pe = prod_t'(p);
    qe = prod_t'(q);
    return pe * qe;
  endfunction

endpackage

/* design/segment_intersection_test.sv */
// closed line segment intersection test, four-stage pipeline
// depends on segit_pkg
//
// Usage: drive the eight endpoint coordinates and raise start for one cycle
// per segment pair. A transaction is accepted at every rising edge where
// start is high and busy is low. busy is never raised: the pipeline takes
// a new pair in every cycle, one pair per clock sustained.
//
// The result appears on segments_meet_o with done_o high once the pair has
// passed the four registered stages (differences, products, sums and
// signs, final decision). Results leave in acceptance order, one per pair.
// The four stages are set by the 32x32 multipliers and the wide adders that
// follow them, each behind its own register.
//
// The result is held for one cycle only; the receiver cannot stall, so no
// backpressure exists and nothing inside ever waits.
//
// Reset (rst_ni low, asynchronous) clears the valid bits of all stages;
// transactions in flight are dropped and done_o stays low until new work
// has passed the pipeline.
module segment_intersection_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  segit_pkg::coord_t  seg1_start_x_i,
  input  segit_pkg::coord_t  seg1_start_y_i,
  input  segit_pkg::coord_t  seg1_end_x_i,
  input  segit_pkg::coord_t  seg1_end_y_i,
  input  segit_pkg::coord_t  seg2_start_x_i,
  input  segit_pkg::coord_t  seg2_start_y_i,
  input  segit_pkg::coord_t  seg2_end_x_i,
  input  segit_pkg::coord_t  seg2_end_y_i,
  output logic               done_o,
  output logic               segments_meet_o
);
  import segit_pkg::*;

  // valid bits per stage
  logic v1_q, v2_q, v3_q, v4_q;
  logic accept;

  // stage 1: coordinate differences
  diffs_t dx_d, dy_d, dx_q, dy_q;
  // stage 2: partial products
  pair_t  cross_d [TestCount];
  pair_t  dot_d   [TestCount];
  pair_t  cross_q [TestCount];
  pair_t  dot_q   [TestCount];
  // stage 3: sign flags
  logic [TestCount-1:0] cr_neg_d, cr_zero_d, dot_le0_d;
  logic [TestCount-1:0] cr_neg_q, cr_zero_q, dot_le0_q;
  // stage 4: decision
  logic meet_d, meet_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // differences of the endpoint coordinates
  always_comb begin
    dx_d.ba = sub(seg1_end_x_i,   seg1_start_x_i);
    dx_d.ca = sub(seg2_start_x_i, seg1_start_x_i);
    dx_d.da = sub(seg2_end_x_i,   seg1_start_x_i);
    dx_d.dc = sub(seg2_end_x_i,   seg2_start_x_i);
    dx_d.ac = sub(seg1_start_x_i, seg2_start_x_i);
    dx_d.bc = sub(seg1_end_x_i,   seg2_start_x_i);
    dx_d.ad = sub(seg1_start_x_i, seg2_end_x_i);
    dx_d.bd = sub(seg1_end_x_i,   seg2_end_x_i);
    dx_d.cb = sub(seg2_start_x_i, seg1_end_x_i);
    dx_d.db = sub(seg2_end_x_i,   seg1_end_x_i);
    dy_d.ba = sub(seg1_end_y_i,   seg1_start_y_i);
    dy_d.ca = sub(seg2_start_y_i, seg1_start_y_i);
    dy_d.da = sub(seg2_end_y_i,   seg1_start_y_i);
    dy_d.dc = sub(seg2_end_y_i,   seg2_start_y_i);
    dy_d.ac = sub(seg1_start_y_i, seg2_start_y_i);
    dy_d.bc = sub(seg1_end_y_i,   seg2_start_y_i);
    dy_d.ad = sub(seg1_start_y_i, seg2_end_y_i);
    dy_d.bd = sub(seg1_end_y_i,   seg2_end_y_i);
    dy_d.cb = sub(seg2_start_y_i, seg1_end_y_i);
    dy_d.db = sub(seg2_end_y_i,   seg1_end_y_i);
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  // one multiplier per partial product
  always_comb begin
    // orientation cross products
    cross_d[T_ABC].p0 = mul(dx_q.ba, dy_q.ca);
    cross_d[T_ABC].p1 = mul(dy_q.ba, dx_q.ca);
    cross_d[T_ABD].p0 = mul(dx_q.ba, dy_q.da);
    cross_d[T_ABD].p1 = mul(dy_q.ba, dx_q.da);
    cross_d[T_CDA].p0 = mul(dx_q.dc, dy_q.ac);
    cross_d[T_CDA].p1 = mul(dy_q.dc, dx_q.ac);
    cross_d[T_CDB].p0 = mul(dx_q.dc, dy_q.bc);
    cross_d[T_CDB].p1 = mul(dy_q.dc, dx_q.bc);
    // dot products for the on-segment range check
    dot_d[T_ABC].p0 = mul(dx_q.ac, dx_q.bc);
    dot_d[T_ABC].p1 = mul(dy_q.ac, dy_q.bc);
    dot_d[T_ABD].p0 = mul(dx_q.ad, dx_q.bd);
    dot_d[T_ABD].p1 = mul(dy_q.ad, dy_q.bd);
    dot_d[T_CDA].p0 = mul(dx_q.ca, dx_q.da);
    dot_d[T_CDA].p1 = mul(dy_q.ca, dy_q.da);
    dot_d[T_CDB].p0 = mul(dx_q.cb, dx_q.db);
    dot_d[T_CDB].p1 = mul(dy_q.cb, dy_q.db);
  end

  always_ff @(posedge clk_i) begin
    cross_q <= cross_d;
    dot_q   <= dot_d;
  end

  // combine products and reduce to sign flags
  always_comb begin
    sum_t cr;
    sum_t dt;
    for (int k = 0; k < TestCount; k++) begin
      cr = sum_t'(cross_q[k].p0) - sum_t'(cross_q[k].p1);
      dt = sum_t'(dot_q[k].p0) + sum_t'(dot_q[k].p1);
      cr_neg_d[k]  = cr[SUM_W-1];
      cr_zero_d[k] = (cr == '0);
      dot_le0_d[k] = dt[SUM_W-1] | (dt == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    cr_neg_q  <= cr_neg_d;
    cr_zero_q <= cr_zero_d;
    dot_le0_q <= dot_le0_d;
  end

  // endpoint-on-segment or proper crossing
  always_comb begin
    logic [TestCount-1:0] on_seg;
    logic ab_split, cd_split;
    on_seg   = cr_zero_q & dot_le0_q;
    ab_split = (cr_neg_q[T_ABC] != cr_neg_q[T_ABD]) |
               (cr_zero_q[T_ABC] != cr_zero_q[T_ABD]);
    cd_split = (cr_neg_q[T_CDA] != cr_neg_q[T_CDB]) |
               (cr_zero_q[T_CDA] != cr_zero_q[T_CDB]);
    meet_d   = (|on_seg) | (ab_split & cd_split);
  end

  always_ff @(posedge clk_i) begin
    meet_q <= meet_d;
  end

  assign done_o          = v4_q;
  assign segments_meet_o = meet_q;

endmodule

/* design/segit_checker.sv */
// port-level checks for the segment intersection test, bound to the top level
// depends on segit_pkg and assert_macros.svh
`include "assert_macros.svh"

module segit_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input segit_pkg::coord_t seg1_start_x_i,
  input segit_pkg::coord_t seg1_start_y_i,
  input segit_pkg::coord_t seg2_start_x_i,
  input segit_pkg::coord_t seg2_start_y_i,
  input logic              done_o,
  input logic              segments_meet_o
);
  import segit_pkg::*;

  logic shared_start;
  assign shared_start = start && !busy &&
                        (seg1_start_x_i == seg2_start_x_i) &&
                        (seg1_start_y_i == seg2_start_y_i);

  // the pipeline never pushes back
  `SEGIT_NEVER(a_never_busy, clk_i, rst_ni, busy)
  // every accepted transaction yields a strobe after the fixed latency
  `SEGIT_ASSERT(a_done_follows, clk_i, rst_ni, start && !busy |-> ##LATENCY done_o)
  // no strobe without a transaction accepted at the right time
  `SEGIT_ASSERT(a_done_origin, clk_i, rst_ni, done_o |-> $past(start && !busy, LATENCY))
  // segments sharing a start point always meet
  `SEGIT_ASSERT(a_shared_point, clk_i, rst_ni, shared_start |-> ##LATENCY segments_meet_o)

endmodule

bind segment_intersection_test segit_checker u_segit_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .seg1_start_x_i (seg1_start_x_i),
  .seg1_start_y_i (seg1_start_y_i),
  .seg2_start_x_i (seg2_start_x_i),
  .seg2_start_y_i (seg2_start_y_i),
  .done_o         (done_o),
  .segments_meet_o(segments_meet_o)
);
